// ----- rtl/fpa_pkg.sv -----
// Package: command codes and control types for the fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;
    localparam int CMD_BITS = 4;

    localparam logic [CMD_BITS-1:0] CMD_FROM_INT = 4'd0;
    localparam logic [CMD_BITS-1:0] CMD_TO_INT   = 4'd1;
    localparam logic [CMD_BITS-1:0] CMD_ROUND    = 4'd2;
    localparam logic [CMD_BITS-1:0] CMD_ADD      = 4'd3;
    localparam logic [CMD_BITS-1:0] CMD_SUB      = 4'd4;
    localparam logic [CMD_BITS-1:0] CMD_ADD_INT  = 4'd5;
    localparam logic [CMD_BITS-1:0] CMD_SUB_INT  = 4'd6;
    localparam logic [CMD_BITS-1:0] CMD_MUL      = 4'd7;
    localparam logic [CMD_BITS-1:0] CMD_DIV      = 4'd8;
    localparam logic [CMD_BITS-1:0] CMD_MUL_INT  = 4'd9;
    localparam logic [CMD_BITS-1:0] CMD_DIV_INT  = 4'd10;

    typedef struct packed {
        logic is_div;
        logic neg;
        logic dz;
    } fpa_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/fpa_front.sv -----
// Front stage: decodes the command, computes non-divide results, prepares divider operands.
`timescale 1ns / 1ps
`default_nettype none
module fpa_front #(
    parameter int FRAC_BITS = 14,
    parameter int WORD_BITS = 32,
    parameter int NUM_BITS  = WORD_BITS + FRAC_BITS
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  [fpa_pkg::CMD_BITS-1:0]  command,
    input  wire  [31:0]                   operand_a,
    input  wire  [31:0]                   operand_b,
    input  wire  [3:0]                    round_shift,
    output logic                          out_valid,
    input  wire                           out_ready,
    output fpa_pkg::fpa_ctl_t             out_ctl,
    output logic [NUM_BITS-1:0]           out_num,
    output logic [WORD_BITS-1:0]          out_den,
    output logic [WORD_BITS-1:0]          out_other
);
    import fpa_pkg::*;

    logic                          valid_reg;
    fpa_ctl_t                      ctl_reg, ctl_next;
    logic [NUM_BITS-1:0]           num_reg, num_next;
    logic [WORD_BITS-1:0]          den_reg, den_next;
    logic [WORD_BITS-1:0]          other_reg, other_next;

    logic signed [WORD_BITS-1:0]   a_w, b_w;
    logic signed [2*WORD_BITS-1:0] prod;
    logic signed [63:0]            a64, b64, prod64, r64, mag, q, n64, nmag, dmag;
    logic [3:0]                    rs_eff;
    logic [5:0]                    fb;

    always_comb begin
        a_w    = operand_a[WORD_BITS-1:0];
        b_w    = operand_b[WORD_BITS-1:0];
        a64    = 64'(a_w);
        b64    = 64'(b_w);
        prod   = a_w * b_w;
        prod64 = 64'(prod);
        mag    = a64[63] ? -a64 : a64;
        rs_eff = (32'(round_shift) >= FRAC_BITS) ? 4'(FRAC_BITS - 1) : round_shift;
        fb     = 6'(FRAC_BITS) - 6'(rs_eff);
        q      = '0;
        unique case (command)
            CMD_FROM_INT: r64 = a64 <<< FRAC_BITS;
            CMD_TO_INT: begin
                q   = mag >> FRAC_BITS;
                r64 = a64[63] ? -q : q;
            end
            CMD_ROUND: begin
                q   = (mag + (64'sd1 << (fb - 6'd1))) >> fb;
                r64 = a64[63] ? -q : q;
            end
            CMD_ADD:     r64 = a64 + b64;
            CMD_SUB:     r64 = a64 - b64;
            CMD_ADD_INT: r64 = a64 + (b64 <<< FRAC_BITS);
            CMD_SUB_INT: r64 = a64 - (b64 <<< FRAC_BITS);
            CMD_MUL:     r64 = prod64 >>> FRAC_BITS;
            CMD_MUL_INT: r64 = prod64;
            default:     r64 = '0;
        endcase
        n64  = (command == CMD_DIV) ? (a64 <<< FRAC_BITS) : a64;
        nmag = n64[63] ? -n64 : n64;
        dmag = b64[63] ? -b64 : b64;

        ctl_next.is_div = (command == CMD_DIV) || (command == CMD_DIV_INT);
        ctl_next.neg    = a_w[WORD_BITS-1] ^ b_w[WORD_BITS-1];
        ctl_next.dz     = ctl_next.is_div && (b_w == '0);
        num_next        = nmag[NUM_BITS-1:0];
        den_next        = dmag[WORD_BITS-1:0];
        other_next      = r64[WORD_BITS-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            ctl_reg   <= ctl_next;
            num_reg   <= num_next;
            den_reg   <= den_next;
            other_reg <= other_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_other = other_reg;
endmodule
`default_nettype wire

// ----- rtl/fpa_div_cell.sv -----
// Divider cell: one restoring quotient bit per stage, carries the rest of the item along.
`timescale 1ns / 1ps
`default_nettype none
module fpa_div_cell #(
    parameter int WORD_BITS = 32,
    parameter int NUM_BITS  = 46
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire fpa_pkg::fpa_ctl_t  in_ctl,
    input  wire  [WORD_BITS-1:0]    in_rem,
    input  wire  [NUM_BITS-1:0]     in_num,
    input  wire  [WORD_BITS-1:0]    in_quot,
    input  wire  [WORD_BITS-1:0]    in_den,
    input  wire  [WORD_BITS-1:0]    in_other,
    output logic                    out_valid,
    input  wire                     out_ready,
    output fpa_pkg::fpa_ctl_t       out_ctl,
    output logic [WORD_BITS-1:0]    out_rem,
    output logic [NUM_BITS-1:0]     out_num,
    output logic [WORD_BITS-1:0]    out_quot,
    output logic [WORD_BITS-1:0]    out_den,
    output logic [WORD_BITS-1:0]    out_other
);
    import fpa_pkg::*;

    logic                   valid_reg;
    fpa_ctl_t               ctl_reg;
    logic [WORD_BITS-1:0]   rem_reg, rem_next;
    logic [NUM_BITS-1:0]    num_reg;
    logic [WORD_BITS-1:0]   quot_reg, quot_next;
    logic [WORD_BITS-1:0]   den_reg;
    logic [WORD_BITS-1:0]   other_reg;
    logic [WORD_BITS:0]     rem_sh, diff;
    logic                   ge;

    always_comb begin
        rem_sh    = {in_rem, in_num[NUM_BITS-1]};
        diff      = rem_sh - {1'b0, in_den};
        ge        = !diff[WORD_BITS];
        rem_next  = ge ? diff[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
        quot_next = {in_quot[WORD_BITS-2:0], ge};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            ctl_reg   <= in_ctl;
            rem_reg   <= rem_next;
            num_reg   <= in_num << 1;
            quot_reg  <= quot_next;
            den_reg   <= in_den;
            other_reg <= in_other;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_quot  = quot_reg;
    assign out_den   = den_reg;
    assign out_other = other_reg;
endmodule
`default_nettype wire

// ----- rtl/fpa_out.sv -----
// Output stage: applies quotient sign and zero-divisor rule, holds the result transfer.
`timescale 1ns / 1ps
`default_nettype none
module fpa_out #(
    parameter int WORD_BITS = 32
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire fpa_pkg::fpa_ctl_t  in_ctl,
    input  wire  [WORD_BITS-1:0]    in_quot,
    input  wire  [WORD_BITS-1:0]    in_other,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic [31:0]             result,
    output logic                    divide_by_zero
);
    import fpa_pkg::*;

    logic                          valid_reg;
    logic [31:0]                   result_reg, result_next;
    logic                          dz_reg;
    logic signed [WORD_BITS-1:0]   res_w;

    always_comb begin
        if (!in_ctl.is_div) begin
            res_w = in_other;
        end else if (in_ctl.dz) begin
            res_w = '0;
        end else if (in_ctl.neg) begin
            res_w = -in_quot;
        end else begin
            res_w = in_quot;
        end
        result_next = 32'(res_w);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            result_reg <= result_next;
            dz_reg     <= in_ctl.dz;
        end
    end

    assign out_valid      = valid_reg;
    assign result         = result_reg;
    assign divide_by_zero = dz_reg;
endmodule
`default_nettype wire

// ----- rtl/fixed_point_alu.sv -----
// Fixed-point ALU top level: front stage, chain of divider cells, output stage.
// Usage:
//   Input transfers on s_t*: each carries a command, two signed operands and a
//   round shift; every input transfer yields exactly one result transfer on m_t*.
//   Results are in order. Every command takes the same path: one front stage,
//   one divider cell per numerator bit, one output stage. Throughput is one
//   item per cycle, set by the cell chain, unless m_tready stalls it; each cell
//   computes one quotient bit of the item it holds.
//   Every stage is a register with its own valid bit; a stage takes a new item
//   when it is empty or its successor takes its current one, so bubbles close
//   up and input is still taken while a finished result waits on m_tready.
//   When m_tready stays low the chain fills and s_tready falls once every stage
//   is full. Reset empties all stages; no result is pending afterwards.
//   Division by zero returns 0 with divide_by_zero set.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu #(
    parameter int FRAC_BITS = 14,
    parameter int WORD_BITS = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [71:0] s_tdata,   // command[3:0], operand_a[35:4], operand_b[67:36],
                                   // round_shift[71:68]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata    // result[31:0], divide_by_zero[32], zero fill[39:33]
);
    import fpa_pkg::*;

    localparam int NUM_BITS = WORD_BITS + FRAC_BITS;

    logic                  v   [NUM_BITS+1];
    logic                  rdy [NUM_BITS+1];
    fpa_ctl_t              ctl [NUM_BITS+1];
    logic [WORD_BITS-1:0]  rem [NUM_BITS+1];
    logic [NUM_BITS-1:0]   num [NUM_BITS+1];
    logic [WORD_BITS-1:0]  quot[NUM_BITS+1];
    logic [WORD_BITS-1:0]  den [NUM_BITS+1];
    logic [WORD_BITS-1:0]  oth [NUM_BITS+1];
    logic [31:0]           result;
    logic                  dz;

    fpa_front #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS),
        .NUM_BITS  (NUM_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .command     (s_tdata[3:0]),
        .operand_a   (s_tdata[35:4]),
        .operand_b   (s_tdata[67:36]),
        .round_shift (s_tdata[71:68]),
        .out_valid   (v[0]),
        .out_ready   (rdy[0]),
        .out_ctl     (ctl[0]),
        .out_num     (num[0]),
        .out_den     (den[0]),
        .out_other   (oth[0])
    );
    assign rem[0]  = '0;
    assign quot[0] = '0;

    for (genvar i = 0; i < NUM_BITS; i++) begin : g_cell
        fpa_div_cell #(
            .WORD_BITS (WORD_BITS),
            .NUM_BITS  (NUM_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (v[i]),
            .in_ready  (rdy[i]),
            .in_ctl    (ctl[i]),
            .in_rem    (rem[i]),
            .in_num    (num[i]),
            .in_quot   (quot[i]),
            .in_den    (den[i]),
            .in_other  (oth[i]),
            .out_valid (v[i+1]),
            .out_ready (rdy[i+1]),
            .out_ctl   (ctl[i+1]),
            .out_rem   (rem[i+1]),
            .out_num   (num[i+1]),
            .out_quot  (quot[i+1]),
            .out_den   (den[i+1]),
            .out_other (oth[i+1])
        );
    end

    fpa_out #(
        .WORD_BITS (WORD_BITS)
    ) u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (v[NUM_BITS]),
        .in_ready       (rdy[NUM_BITS]),
        .in_ctl         (ctl[NUM_BITS]),
        .in_quot        (quot[NUM_BITS]),
        .in_other       (oth[NUM_BITS]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .result         (result),
        .divide_by_zero (dz)
    );

    assign m_tdata = {7'd0, dz, result};

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[31:0] == 32'd0)
        else $error("zero-divisor result not zero");

    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output stage can drain");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
endmodule
`default_nettype wire
